### rtl/cuckoo_hash_table_assert.svh
// Assertion macros for the cuckoo hash table checker.
// Each samples on clock and is off while reset is high.
`ifndef CUCKOO_HASH_TABLE_ASSERT_SVH
`define CUCKOO_HASH_TABLE_ASSERT_SVH

// Same-cycle implication.
`define CHT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cuckoo hash table check failed");

// Next-cycle implication.
`define CHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cuckoo hash table check failed");

`endif

### rtl/cht_pkg.sv
`default_nettype none
package cht_pkg;

   localparam int TABLE_DEPTH = 8192;
   localparam int MAX_KICKS   = 32;
   localparam int HIGH_WINDOW = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int KICK_W      = $clog2(MAX_KICKS + 1);
   localparam int COUNT_W     = 14;
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(16383);

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_PROBE  = 1'b1;

   // One table entry: key zero marks an empty slot
   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  piece;
      logic [5:0]  from_sq;
      logic [5:0]  to_sq;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [ADDR_W-1:0] first_slot(input logic [63:0] key);
      logic [63:0] masked;
      masked = key & 64'(TABLE_DEPTH - 1);
      return masked[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] second_slot(input logic [63:0] key);
      return first_slot(key >> HIGH_WINDOW);
   endfunction

endpackage
`default_nettype wire

### rtl/cht_ram.sv
`default_nettype none
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/cuckoo_hash_table.sv
`default_nettype none
// Two-choice cuckoo hash table of 64-bit keys with a 16-bit payload.
// Request channel: start with the req_ fields; a request is taken at a clock
// edge where start is high and busy is low. req_mode 0 inserts req_key_a with
// its payload, req_mode 1 probes for req_key_a ^ req_key_b (^ side key when
// req_gap_odd is set). One result per request appears on the rsp_ ports for
// exactly one cycle, flagged by rsp_strobe; the receiver cannot stall it.
// Config: csr_data is written into the side key when csr_valid is high;
// csr_ready is always high.
// A probe reads slot one and shows its result from there when slot one holds
// the key, or the key is zero, and reads slot two otherwise. An insert makes
// up to 32 placements, one read-modify-write of the single entry RAM per
// cycle. busy stays high until the result is shown, so one request is in
// flight at a time.
// Reset: the side key and entry count clear at once, then a clearing pass
// writes zero to all 8192 entries, one per cycle; busy is high throughout
// the pass.
module cuckoo_hash_table
   import cht_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic [63:0]        req_key_a,
   input  wire logic [63:0]        req_key_b,
   input  wire logic               req_gap_odd,
   input  wire logic [3:0]         req_piece_type,
   input  wire logic [5:0]         req_move_from,
   input  wire logic [5:0]         req_move_to,
   output logic                    rsp_strobe,
   output logic                    rsp_found,
   output logic [3:0]              rsp_found_piece,
   output logic [5:0]              rsp_found_from,
   output logic [5:0]              rsp_found_to,
   output logic                    rsp_insert_failed,
   output logic [COUNT_W-1:0]      rsp_entry_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [63:0]        csr_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE1,
      ST_PROBE2,
      ST_SWAP
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [KICK_W-1:0] LAST_KICK = KICK_W'(MAX_KICKS - 1);

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [63:0]         side_key_ff;
   logic [COUNT_W-1:0]  count_ff, count_in;
   entry_type           hand_ff, hand_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [KICK_W-1:0]   kick_ff, kick_in;
   logic                fwd_ff, fwd_in;
   entry_type           fwd_data_ff, fwd_data_in;
   logic                strobe_ff, strobe_in;
   logic                found_ff, found_in;
   logic [3:0]          piece_ff, piece_in;
   logic [5:0]          from_ff, from_in;
   logic [5:0]          to_ff, to_in;
   logic                failed_ff, failed_in;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   entry_type           ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_q;
   entry_type           read_word;
   logic [63:0]         probe_key;
   logic [ADDR_W-1:0]   next_slot;

   cht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_q)
   );

   // Forward the entry written last cycle when the same slot is read back
   assign read_word = fwd_ff ? fwd_data_ff : entry_type'(ram_rd_q);

   assign probe_key = req_key_a ^ req_key_b ^ (req_gap_odd ? side_key_ff : 64'd0);
   assign next_slot = (slot_ff == first_slot(read_word.key)) ?
                      second_slot(read_word.key) : first_slot(read_word.key);

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_strobe        = strobe_ff;
   assign rsp_found         = found_ff;
   assign rsp_found_piece   = piece_ff;
   assign rsp_found_from    = from_ff;
   assign rsp_found_to      = to_ff;
   assign rsp_insert_failed = failed_ff;
   assign rsp_entry_count   = count_ff;

   // Clear the table after reset, then sequence requests through read, compare, swap and write back
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      count_in    = count_ff;
      hand_in     = hand_ff;
      slot_in     = slot_ff;
      kick_in     = kick_ff;
      fwd_in      = 1'b0;
      fwd_data_in = fwd_data_ff;
      strobe_in   = 1'b0;
      found_in    = found_ff;
      piece_in    = piece_ff;
      from_in     = from_ff;
      to_in       = to_ff;
      failed_in   = failed_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = hand_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = slot_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ram_rd_en = 1'b1;
               if (req_mode == MODE_PROBE) begin
                  hand_in.key = probe_key;
                  ram_rd_addr = first_slot(probe_key);
                  state_in    = ST_PROBE1;
               end else begin
                  hand_in.key     = req_key_a;
                  hand_in.piece   = req_piece_type;
                  hand_in.from_sq = req_move_from;
                  hand_in.to_sq   = req_move_to;
                  slot_in         = first_slot(req_key_a);
                  ram_rd_addr     = first_slot(req_key_a);
                  kick_in         = '0;
                  state_in        = ST_SWAP;
               end
            end
         end
         ST_PROBE1: begin
            if (hand_ff.key == 64'd0 || read_word.key == hand_ff.key) begin
               // Zero key never matches; otherwise slot one hit
               strobe_in = 1'b1;
               failed_in = 1'b0;
               found_in  = (hand_ff.key != 64'd0);
               piece_in  = found_in ? read_word.piece   : 4'd0;
               from_in   = found_in ? read_word.from_sq : 6'd0;
               to_in     = found_in ? read_word.to_sq   : 6'd0;
               state_in  = ST_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = second_slot(hand_ff.key);
               state_in    = ST_PROBE2;
            end
         end
         ST_PROBE2: begin
            strobe_in = 1'b1;
            failed_in = 1'b0;
            found_in  = (read_word.key == hand_ff.key);
            piece_in  = found_in ? read_word.piece   : 4'd0;
            from_in   = found_in ? read_word.from_sq : 6'd0;
            to_in     = found_in ? read_word.to_sq   : 6'd0;
            state_in  = ST_IDLE;
         end
         ST_SWAP: begin
            found_in = 1'b0;
            piece_in = 4'd0;
            from_in  = 6'd0;
            to_in    = 6'd0;
            if (hand_ff.key == 64'd0) begin
               // Drop an insert of key zero
               strobe_in = 1'b1;
               failed_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               // Place the entry in hand, pick up the one it displaces
               ram_wr_en   = 1'b1;
               hand_in     = read_word;
               fwd_data_in = hand_ff;
               kick_in     = kick_ff + KICK_W'(1);
               if (read_word.key == 64'd0) begin
                  strobe_in = 1'b1;
                  failed_in = 1'b0;
                  if (count_ff < COUNT_MAX) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
                  state_in = ST_IDLE;
               end else if (kick_ff == LAST_KICK) begin
                  strobe_in = 1'b1;
                  failed_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = next_slot;
                  slot_in     = next_slot;
                  fwd_in      = (next_slot == slot_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         side_key_ff <= '0;
         count_ff    <= '0;
         fwd_ff      <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         count_ff  <= count_in;
         fwd_ff    <= fwd_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            side_key_ff <= csr_data;
         end
      end
      hand_ff     <= hand_in;
      slot_ff     <= slot_in;
      kick_ff     <= kick_in;
      fwd_data_ff <= fwd_data_in;
      found_ff    <= found_in;
      piece_ff    <= piece_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      failed_ff   <= failed_in;
   end

endmodule
`default_nettype wire

### rtl/cht_checker.sv
`default_nettype none
`include "cuckoo_hash_table_assert.svh"
module cht_checker
   import cht_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic               rsp_strobe,
   input  wire logic               rsp_found,
   input  wire logic [3:0]         rsp_found_piece,
   input  wire logic [5:0]         rsp_found_from,
   input  wire logic [5:0]         rsp_found_to,
   input  wire logic               rsp_insert_failed
);

   // A taken request keeps the block busy until its result
   `CHT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)

   // Results are never back to back
   `CHT_ASSERT_NEXT(a_strobe_spacing, rsp_strobe, !rsp_strobe)

   // A failed insert never reports a match
   `CHT_ASSERT_NOW(a_fail_no_found, rsp_strobe && rsp_insert_failed, !rsp_found)

   // A miss carries an all-zero payload
   `CHT_ASSERT_NOW(a_miss_zero, rsp_strobe && !rsp_found,
      rsp_found_piece == 4'd0 && rsp_found_from == 6'd0 && rsp_found_to == 6'd0)

endmodule

bind cuckoo_hash_table cht_checker u_cht_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_found         (rsp_found),
   .rsp_found_piece   (rsp_found_piece),
   .rsp_found_from    (rsp_found_from),
   .rsp_found_to      (rsp_found_to),
   .rsp_insert_failed (rsp_insert_failed)
);
`default_nettype wire
